[rtl/dpcm_gap_pixel_predictor_top_defines.svh]
// Assertion macros shared by the predictor RTL.
// Every check runs on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef DPCM_GAP_PIXEL_PREDICTOR_TOP_DEFINES_SVH
`define DPCM_GAP_PIXEL_PREDICTOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DGP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dpcm_gap_pkg.sv]
`timescale 1ns / 1ps

package dpcm_gap_pkg;

    // Sizes of the pixel stream and of the line buffers.
    localparam int PIXEL_BITS = 8;
    localparam int MAX_WIDTH  = 4096;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = 13;
    localparam int MODE_BITS  = 3;
    localparam int ERR_BITS   = 10;
    localparam int TAG_BITS   = 2;
    // Internal signed width for predictions and differences.
    localparam int PRED_BITS  = PIXEL_BITS + 4;

    localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_W = WIDTH_BITS'(4);
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_W = WIDTH_BITS'(MAX_WIDTH);

    // Prediction for the first pixel of a frame.
    localparam int MID_GRAY = 1 << (PIXEL_BITS - 1);

    // GAP gradient thresholds.
    localparam int GAP_T_STRONG = 80;
    localparam int GAP_T_MID    = 32;
    localparam int GAP_T_WEAK   = 8;

    // Saturation limits of the prediction error.
    localparam int ERR_MAX = (1 << (ERR_BITS - 1)) - 1;
    localparam int ERR_MIN = -(1 << (ERR_BITS - 1));

    // Interior predictor codes; unlisted codes act as west.
    localparam logic [MODE_BITS-1:0] MODE_WEST    = MODE_BITS'(1);
    localparam logic [MODE_BITS-1:0] MODE_NORTH   = MODE_BITS'(2);
    localparam logic [MODE_BITS-1:0] MODE_AVERAGE = MODE_BITS'(3);
    localparam logic [MODE_BITS-1:0] MODE_CALIC   = MODE_BITS'(4);

    // Register indexes on the configuration port.
    localparam logic REG_PREDICT_MODE = 1'b0;
    localparam logic REG_IMAGE_WIDTH  = 1'b1;

    typedef logic [PIXEL_BITS-1:0] t_pixel;

    typedef enum logic [TAG_BITS-1:0] {
        TAG_BIN_WEST  = 2'd0,
        TAG_BIN_OTHER = 2'd1,
        TAG_GAP       = 2'd2,
        TAG_NONE      = 2'd3
    } t_mode_tag;

    typedef enum logic [1:0] {
        ROW_FIRST  = 2'd0,
        ROW_SECOND = 2'd1,
        ROW_LATER  = 2'd2
    } t_row_phase;

    // Causal neighborhood of the current pixel.
    typedef struct packed {
        t_pixel w;
        t_pixel n;
        t_pixel ww;
        t_pixel nn;
        t_pixel nw;
        t_pixel ne;
        t_pixel nne;
    } t_nbhd;

    // Position of the current pixel within the frame.
    typedef struct packed {
        t_row_phase row;
        logic       col_zero;
        logic       col_lt2;
        logic       last;
    } t_pos;

endpackage

[rtl/dpcm_gap_ram.sv]
`timescale 1ns / 1ps

module dpcm_gap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

[rtl/dpcm_gap_predict.sv]
`timescale 1ns / 1ps

module dpcm_gap_predict (
    input  dpcm_gap_pkg::t_pixel                        i_pixel,
    input  dpcm_gap_pkg::t_nbhd                         i_nbhd,
    input  dpcm_gap_pkg::t_pos                          i_pos,
    input  logic [dpcm_gap_pkg::MODE_BITS-1:0]          i_mode,
    output logic signed [dpcm_gap_pkg::ERR_BITS-1:0]    o_pred_error,
    output dpcm_gap_pkg::t_mode_tag                     o_mode_tag
);

    import dpcm_gap_pkg::*;

    // Zero-extend a pixel into the signed working width.
    function automatic logic signed [PRED_BITS-1:0] ext(input t_pixel v);
        return $signed({{(PRED_BITS - PIXEL_BITS){1'b0}}, v});
    endfunction

    // Absolute difference of two pixels, widened.
    function automatic logic signed [PRED_BITS-1:0] absd(input t_pixel a, input t_pixel b);
        return (a > b) ? ext(a - b) : ext(b - a);
    endfunction

    t_pixel                      nb [7];
    t_pixel                      other;
    logic                        have_other;
    logic                        two_val;
    logic signed [PRED_BITS-1:0] dh;
    logic signed [PRED_BITS-1:0] dv;
    logic signed [PRED_BITS-1:0] diff;
    logic signed [PRED_BITS-1:0] p0;
    logic signed [PRED_BITS-1:0] dne;
    logic signed [PRED_BITS-1:0] dne_adj;
    logic signed [PRED_BITS-1:0] p;
    logic signed [PRED_BITS-1:0] p_adj;
    logic signed [PRED_BITS-1:0] p_half;
    logic signed [PRED_BITS-1:0] p3;
    logic signed [PRED_BITS-1:0] p3_adj;
    logic signed [PRED_BITS-1:0] p3q;
    logic signed [PRED_BITS-1:0] gap_pred;
    logic signed [PRED_BITS-1:0] pred;
    logic signed [PRED_BITS-1:0] err;
    t_mode_tag                   tag;

    // Neighbors in the order the binary-mode scan visits them.
    always_comb begin
        nb[0] = i_nbhd.w;
        nb[1] = i_nbhd.n;
        nb[2] = i_nbhd.ww;
        nb[3] = i_nbhd.nn;
        nb[4] = i_nbhd.nw;
        nb[5] = i_nbhd.ne;
        nb[6] = i_nbhd.nne;
    end

    // Binary mode: at most one value besides W, taken from the first neighbor that differs.
    always_comb begin
        other      = nb[0];
        have_other = 1'b0;
        two_val    = 1'b1;
        for (int k = 6; k >= 1; k--) begin
            if (nb[k] != nb[0]) begin
                other      = nb[k];
                have_other = 1'b1;
            end
        end
        for (int k = 1; k < 7; k++) begin
            if ((nb[k] != nb[0]) && (nb[k] != other)) begin
                two_val = 1'b0;
            end
        end
    end

    // GAP gradients and the blended prediction; divisions truncate toward zero.
    always_comb begin
        dh = absd(i_nbhd.w, i_nbhd.ww) + absd(i_nbhd.n, i_nbhd.nw)
           + absd(i_nbhd.ne, i_nbhd.n);
        dv = absd(i_nbhd.w, i_nbhd.nw) + absd(i_nbhd.n, i_nbhd.nn)
           + absd(i_nbhd.ne, i_nbhd.nne);
        diff = dv - dh;

        p0      = (ext(i_nbhd.w) + ext(i_nbhd.n)) >>> 1;
        dne     = ext(i_nbhd.ne) - ext(i_nbhd.nw);
        dne_adj = dne + (dne[PRED_BITS-1] ? PRED_BITS'(3) : PRED_BITS'(0));
        p       = p0 + (dne_adj >>> 2);

        p_adj  = p + (p[PRED_BITS-1] ? PRED_BITS'(1) : PRED_BITS'(0));
        p_half = p_adj >>> 1;
        p3     = (p <<< 1) + p;
        p3_adj = p3 + (p3[PRED_BITS-1] ? PRED_BITS'(3) : PRED_BITS'(0));
        p3q    = p3_adj >>> 2;

        if (diff > GAP_T_STRONG) begin
            gap_pred = ext(i_nbhd.w);
        end else if (diff < -GAP_T_STRONG) begin
            gap_pred = ext(i_nbhd.n);
        end else if (diff > GAP_T_MID) begin
            gap_pred = p_half + (ext(i_nbhd.w) >>> 1);
        end else if (diff < -GAP_T_MID) begin
            gap_pred = p_half + (ext(i_nbhd.n) >>> 1);
        end else if (diff > GAP_T_WEAK) begin
            gap_pred = p3q + (ext(i_nbhd.w) >>> 2);
        end else if (diff < -GAP_T_WEAK) begin
            gap_pred = p3q + (ext(i_nbhd.n) >>> 2);
        end else begin
            gap_pred = p;
        end
    end

    // Select the predictor by position and configured mode.
    always_comb begin
        tag  = TAG_NONE;
        pred = ext(i_nbhd.w);
        case (i_pos.row)
            ROW_FIRST: begin
                pred = i_pos.col_zero ? PRED_BITS'(MID_GRAY) : ext(i_nbhd.w);
            end
            ROW_SECOND: begin
                pred = ext(i_nbhd.n);
            end
            default: begin
                if (i_pos.col_lt2 || i_pos.last) begin
                    pred = ext(i_nbhd.n);
                end else begin
                    case (i_mode)
                        MODE_NORTH: begin
                            pred = ext(i_nbhd.n);
                        end
                        MODE_AVERAGE: begin
                            pred = (ext(i_nbhd.w) >>> 1) + (ext(i_nbhd.n) >>> 1);
                        end
                        MODE_CALIC: begin
                            if (two_val && (i_pixel == i_nbhd.w)) begin
                                tag  = TAG_BIN_WEST;
                                pred = ext(i_pixel);
                            end else if (two_val && have_other) begin
                                tag  = TAG_BIN_OTHER;
                                pred = ext(other);
                            end else begin
                                tag  = TAG_GAP;
                                pred = gap_pred;
                            end
                        end
                        default: begin
                            pred = ext(i_nbhd.w);
                        end
                    endcase
                end
            end
        endcase
    end

    // Error with saturation to the output range.
    always_comb begin
        err = ext(i_pixel) - pred;
        if (err > ERR_MAX) begin
            o_pred_error = ERR_BITS'(ERR_MAX);
        end else if (err < ERR_MIN) begin
            o_pred_error = ERR_BITS'(ERR_MIN);
        end else begin
            o_pred_error = err[ERR_BITS-1:0];
        end
        o_mode_tag = tag;
    end

endmodule

[rtl/dpcm_gap_pixel_predictor_top.sv]
`timescale 1ns / 1ps
`include "dpcm_gap_pixel_predictor_top_defines.svh"

// GAP/DPCM pixel predictor. Pixels enter in raster order, one per clock while the
// output is not stalled, and each produces one saturated 10-bit prediction error and
// a 2-bit mode tag. A transaction with frame_start set becomes pixel (0,0) of a new
// image. Stage 1 registers the pixel while the two line buffers (dual-read RAMs
// holding rows i-1 and i-2) return columns c and c+1; the result register then takes
// the prediction computed from it. Values written back to the line buffers are
// forwarded to the next pixel when it reads the same entry. Line buffer contents are
// not cleared at reset, so a frame must start with a full first row before later
// rows depend on it; changing image_width in mid-frame reads stale entries.
// Configuration: predict_mode at byte address 0, image_width at byte address 4; write
// them only while no transaction is in flight.
module dpcm_gap_pixel_predictor_top (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // Pixel input channel.
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  dpcm_gap_pkg::t_pixel                        i_pixel,
    input  logic                                        i_frame_start,
    // Result output channel.
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic signed [dpcm_gap_pkg::ERR_BITS-1:0]    o_pred_error,
    output logic [dpcm_gap_pkg::TAG_BITS-1:0]           o_mode_tag,
    // Configuration port.
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [2:0]                                  paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);

    import dpcm_gap_pkg::*;

    // Configuration registers.
    logic [MODE_BITS-1:0]  r_predict_mode;
    logic [WIDTH_BITS-1:0] r_image_width;
    logic                  cfg_wr;

    // Position counters, advanced at input acceptance.
    logic [COL_BITS-1:0]   r_col;
    logic [COL_BITS-1:0]   n_col;
    t_row_phase            r_row;
    t_row_phase            n_row;

    // Stage 1: registered pixel and position.
    logic                  r_s1_valid;
    logic                  n_s1_valid;
    t_pixel                r_s1_pixel;
    logic [COL_BITS-1:0]   r_s1_col;
    t_pos                  r_s1_pos;
    t_row_phase            r_s1_row;

    // Forwarding of the write from the pixel ahead.
    logic                  r_byp_a;
    logic                  r_byp_b;
    t_pixel                r_byp_above;
    t_pixel                r_byp_two;

    // Pixels of the current row and the last north value.
    t_pixel                r_west;
    t_pixel                r_west_west;
    t_pixel                r_north_west;

    // Result register.
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [ERR_BITS-1:0]   r_pred_error;
    t_mode_tag             r_mode_tag;

    // Handshake and accept-side position.
    logic                  in_acc;
    logic                  s1_adv;
    logic                  s1_fire;
    logic [WIDTH_BITS-1:0] width_sat;
    logic [WIDTH_BITS-1:0] width_m1;
    logic [COL_BITS-1:0]   acc_col;
    logic [COL_BITS-1:0]   acc_col_p1;
    t_row_phase            acc_row;
    logic                  acc_last;

    // Line buffer read data and the resolved neighborhood.
    t_pixel                above_rd_a;
    t_pixel                above_rd_b;
    t_pixel                two_rd_a;
    t_pixel                two_rd_b;
    t_pixel                north_cur;
    t_nbhd                 nbhd;
    logic [ERR_BITS-1:0]   calc_error;
    t_mode_tag             calc_tag;

    // Configuration port: always ready, registers read back as written.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == REG_IMAGE_WIDTH) begin
            prdata = {{(32 - WIDTH_BITS){1'b0}}, r_image_width};
        end else begin
            prdata = {{(32 - MODE_BITS){1'b0}}, r_predict_mode};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_predict_mode <= MODE_WEST;
            r_image_width  <= MAX_WIDTH_W;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PREDICT_MODE) begin
                r_predict_mode <= pwdata[MODE_BITS-1:0];
            end else begin
                r_image_width <= pwdata[WIDTH_BITS-1:0];
            end
        end
    end

    // Handshake: stage 1 moves on whenever the result register is free or being drained.
    assign s1_adv      = !r_out_valid || i_out_ready;
    assign s1_fire     = r_s1_valid && s1_adv;
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_in_valid && o_in_ready;

    // Effective row width, saturated to the supported range.
    always_comb begin
        if (r_image_width < MIN_WIDTH_W) begin
            width_sat = MIN_WIDTH_W;
        end else if (r_image_width > MAX_WIDTH_W) begin
            width_sat = MAX_WIDTH_W;
        end else begin
            width_sat = r_image_width;
        end
        width_m1 = width_sat - WIDTH_BITS'(1);
    end

    // Position of the accepted pixel and the counters after it.
    always_comb begin
        acc_col    = i_frame_start ? '0 : r_col;
        acc_row    = i_frame_start ? ROW_FIRST : r_row;
        acc_col_p1 = acc_col + COL_BITS'(1);
        acc_last   = {1'b0, acc_col} >= width_m1;
        n_col      = acc_last ? '0 : acc_col_p1;
        n_row      = acc_row;
        if (acc_last) begin
            case (acc_row)
                ROW_FIRST:  n_row = ROW_SECOND;
                ROW_SECOND: n_row = ROW_LATER;
                default:    n_row = ROW_LATER;
            endcase
        end
    end

    // Next values of the valid flags.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= ROW_FIRST;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_byp_a      <= 1'b0;
            r_byp_b      <= 1'b0;
            r_west       <= '0;
            r_west_west  <= '0;
            r_north_west <= '0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_byp_a <= s1_fire && (acc_col == r_s1_col);
                r_byp_b <= s1_fire && (acc_col_p1 == r_s1_col);
            end
            if (s1_fire) begin
                r_west       <= r_s1_pixel;
                r_west_west  <= r_west;
                r_north_west <= north_cur;
            end
        end
    end

    // Stage 1 and result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel        <= i_pixel;
            r_s1_col          <= acc_col;
            r_s1_row          <= acc_row;
            r_s1_pos.row      <= acc_row;
            r_s1_pos.col_zero <= (acc_col == '0);
            r_s1_pos.col_lt2  <= (acc_col < COL_BITS'(2));
            r_s1_pos.last     <= acc_last;
            r_byp_above       <= r_s1_pixel;
            r_byp_two         <= north_cur;
        end
        if (s1_fire) begin
            r_pred_error <= calc_error;
            r_mode_tag   <= calc_tag;
        end
    end

    // Line buffers: row i-1 and row i-2, written once per pixel at its column.
    dpcm_gap_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk       (i_clk),
        .i_wr_en     (s1_fire),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (r_s1_pixel),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (acc_col),
        .i_rd_addr_b (acc_col_p1),
        .o_rd_data_a (above_rd_a),
        .o_rd_data_b (above_rd_b)
    );

    dpcm_gap_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk       (i_clk),
        .i_wr_en     (s1_fire),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (north_cur),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (acc_col),
        .i_rd_addr_b (acc_col_p1),
        .o_rd_data_a (two_rd_a),
        .o_rd_data_b (two_rd_b)
    );

    // Neighborhood of the stage 1 pixel, with forwarding from the write ahead of it.
    always_comb begin
        north_cur = r_byp_a ? r_byp_above : above_rd_a;
        nbhd.w    = r_west;
        nbhd.n    = north_cur;
        nbhd.ww   = r_west_west;
        nbhd.nn   = r_byp_a ? r_byp_two : two_rd_a;
        nbhd.nw   = r_north_west;
        nbhd.ne   = r_byp_b ? r_byp_above : above_rd_b;
        nbhd.nne  = r_byp_b ? r_byp_two : two_rd_b;
    end

    dpcm_gap_predict u_predict (
        .i_pixel      (r_s1_pixel),
        .i_nbhd       (nbhd),
        .i_pos        (r_s1_pos),
        .i_mode       (r_predict_mode),
        .o_pred_error (calc_error),
        .o_mode_tag   (calc_tag)
    );

    // Output channel.
    assign o_out_valid  = r_out_valid;
    assign o_pred_error = r_pred_error;
    assign o_mode_tag   = r_mode_tag;

    // A stalled stage 1 keeps its pixel.
    `DGP_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_adv, r_s1_valid, "stage 1 pixel lost while stalled")
    // A pixel leaving stage 1 lands in the result register.
    `DGP_ASSERT_NEXT(a_s1_to_out, s1_fire, r_out_valid, "result register not loaded")
    // A frame start restarts the position at the top left corner.
    `DGP_ASSERT_NEXT(a_frame_restart, in_acc && i_frame_start, (r_s1_col == '0) && (r_s1_row == ROW_FIRST), "frame start did not reset position")
    // Forwarding can match the column or the column after it but never both.
    `DGP_ASSERT_SAME(a_bypass_excl, r_s1_valid, !(r_byp_a && r_byp_b), "both forwarding paths selected")

endmodule

[dv/dpcm_gap_checker.sv]
`timescale 1ns / 1ps

// Watches the pixel, result and configuration channels of the predictor, keeps its own
// copy of the line buffers and neighbor registers, and checks every result transaction
// against the prediction made when the matching pixel transaction was accepted.
module dpcm_gap_checker
    import dpcm_gap_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  t_pixel                      i_pixel,
    input  logic                        i_frame_start,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [ERR_BITS-1:0]  i_pred_error,
    input  logic [TAG_BITS-1:0]         i_mode_tag,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [2:0]                  i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count,
    output logic [3:0]                  o_tags_seen
);

    typedef struct packed {
        logic signed [ERR_BITS-1:0] err;
        t_mode_tag                  tag;
    } t_pixel_result;

    // Predicted results, oldest first.
    t_pixel_result predicted_results [$];

    // Shadow copy of the predictor state and its configuration.
    t_pixel                 line_above     [MAX_WIDTH];
    t_pixel                 line_two_above [MAX_WIDTH];
    t_pixel                 west_pixel;
    t_pixel                 west_west_pixel;
    t_pixel                 north_west_pixel;
    int                     col_count;
    t_row_phase             row_phase;
    logic [MODE_BITS-1:0]   cfg_mode;
    logic [WIDTH_BITS-1:0]  cfg_width;

    initial begin
        foreach (line_above[i]) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_tags_seen    = '0;
    end

    function automatic int abs_diff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Gradient-adjusted prediction with the three threshold bands.
    function automatic int grad_predict(int w, int n, int ww, int nn, int nw, int ne,
                                        int nne);
        int dh;
        int dv;
        int p;
        dh = abs_diff(w, ww) + abs_diff(n, nw) + abs_diff(ne, n);
        dv = abs_diff(w, nw) + abs_diff(n, nn) + abs_diff(ne, nne);
        if (dv - dh > GAP_T_STRONG) return w;
        if (dh - dv > GAP_T_STRONG) return n;
        p = (w + n) / 2 + (ne - nw) / 4;
        if (dv - dh > GAP_T_MID) p = p / 2 + w / 2;
        else if (dh - dv > GAP_T_MID) p = p / 2 + n / 2;
        else if (dv - dh > GAP_T_WEAK) p = (p * 3) / 4 + w / 4;
        else if (dh - dv > GAP_T_WEAK) p = (p * 3) / 4 + n / 4;
        return p;
    endfunction

    // Computes the error and tag of one pixel and advances the shadow state.
    task automatic predict_pixel(input t_pixel pix, input logic frame_first,
                                 output t_pixel_result res);
        int        x;
        int        w;
        int        n;
        int        pred;
        int        err;
        int        eff;
        int        col;
        int        other;
        int        distinct;
        int        nb [7];
        logic      last;
        logic      have_other;
        t_pixel    north;
        t_mode_tag tag;

        if (frame_first) begin
            col_count = 0;
            row_phase = ROW_FIRST;
        end
        eff = int'(cfg_width);
        if (eff < int'(MIN_WIDTH_W)) eff = int'(MIN_WIDTH_W);
        if (eff > MAX_WIDTH) eff = MAX_WIDTH;
        col   = col_count;
        last  = (col >= eff - 1);
        north = line_above[col];
        x     = int'(pix);
        w     = int'(west_pixel);
        n     = int'(north);
        tag   = TAG_NONE;
        pred  = w;

        if (row_phase == ROW_FIRST) begin
            pred = (col == 0) ? MID_GRAY : w;
        end else if (row_phase == ROW_SECOND || col < 2 || last) begin
            pred = n;
        end else begin
            case (cfg_mode)
                MODE_NORTH: begin
                    pred = n;
                end
                MODE_AVERAGE: begin
                    pred = w / 2 + n / 2;
                end
                MODE_CALIC: begin
                    nb[0] = w;
                    nb[1] = n;
                    nb[2] = int'(west_west_pixel);
                    nb[3] = int'(line_two_above[col]);
                    nb[4] = int'(north_west_pixel);
                    nb[5] = (col + 1 < MAX_WIDTH) ? int'(line_above[col + 1]) : 0;
                    nb[6] = (col + 1 < MAX_WIDTH) ? int'(line_two_above[col + 1]) : 0;
                    // Count distinct values; the last neighbor may supply the second one.
                    have_other = 1'b0;
                    other      = 0;
                    distinct   = 1;
                    for (int k = 1; k < 7; k++) begin
                        if (nb[k] != nb[0]) begin
                            if (!have_other) begin
                                have_other = 1'b1;
                                other      = nb[k];
                                distinct   = 2;
                            end else if (nb[k] != other) begin
                                distinct = 3;
                            end
                        end
                    end
                    if (distinct <= 2 && x == w) begin
                        tag  = TAG_BIN_WEST;
                        pred = x;
                    end else if (distinct == 2) begin
                        tag  = TAG_BIN_OTHER;
                        pred = other;
                    end else begin
                        tag  = TAG_GAP;
                        pred = grad_predict(nb[0], nb[1], nb[2], nb[3], nb[4], nb[5],
                                            nb[6]);
                    end
                end
                default: begin
                    pred = w;
                end
            endcase
        end

        err = x - pred;
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;
        res.err = ERR_BITS'(err);
        res.tag = tag;

        // Write back the line buffers and shift the neighbor registers.
        line_two_above[col] = north;
        line_above[col]     = pix;
        north_west_pixel    = north;
        west_west_pixel     = west_pixel;
        west_pixel          = pix;
        if (last) begin
            col_count = 0;
            if (row_phase != ROW_LATER) row_phase = t_row_phase'(row_phase + 1);
        end else begin
            col_count = col + 1;
        end
    endtask

    // Compare results, track register writes, then predict accepted pixels.
    always @(posedge i_clk) begin : monitor
        t_pixel_result want;
        if (!i_rst_n) begin
            west_pixel       = '0;
            west_west_pixel  = '0;
            north_west_pixel = '0;
            col_count        = 0;
            row_phase        = ROW_FIRST;
            cfg_mode         = MODE_WEST;
            cfg_width        = MAX_WIDTH_W;
            predicted_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result transaction with no pixel waiting: pred_error %0d",
                           $signed(i_pred_error));
                    o_fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (i_pred_error !== want.err) begin
                        $error("pred_error mismatch: expected %0d, actual %0d",
                               $signed(want.err), $signed(i_pred_error));
                        o_fail_count++;
                    end
                    if (i_mode_tag !== want.tag) begin
                        $error("mode_tag mismatch: expected %0d, actual %0d",
                               want.tag, i_mode_tag);
                        o_fail_count++;
                    end
                    o_result_count++;
                    o_tags_seen[want.tag] = 1'b1;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_PREDICT_MODE: cfg_mode  = i_pwdata[MODE_BITS-1:0];
                    default:          cfg_width = i_pwdata[WIDTH_BITS-1:0];
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_pixel(i_pixel, i_frame_start, want);
                predicted_results.push_back(want);
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

[dv/tb_dpcm_gap_pixel_predictor_top.sv]
`timescale 1ns / 1ps

module tb_dpcm_gap_pixel_predictor_top;
    import dpcm_gap_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PHASE_ITEMS     = 85;
    localparam int NUM_PHASES      = 8;

    typedef enum int {
        STYLE_NOISE,
        STYLE_TWO_TONE,
        STYLE_THREE_TONE,
        STYLE_RAMP,
        STYLE_STEP,
        STYLE_EXTREME
    } t_style;

    // Block ports; every input is driven to a known value from time zero.
    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_ready;
    t_pixel                     i_pixel       = '0;
    logic                       i_frame_start = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready   = 1'b0;
    logic signed [ERR_BITS-1:0] o_pred_error;
    logic [TAG_BITS-1:0]        o_mode_tag;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic [2:0]                 paddr         = '0;
    logic [31:0]                pwdata        = '0;
    logic [31:0]                prdata;
    logic                       pready;

    int         fail_count;
    int         pending;
    int         result_count;
    logic [3:0] tags_seen;

    int     cycle_count    = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     items_sent     = 0;
    int     frames_sent    = 0;
    int     cur_width      = MAX_WIDTH;

    // Content of the frame being sent.
    t_style frame_style;
    t_pixel tone_a;
    t_pixel tone_b;
    t_pixel tone_c;
    int     ramp_h;
    int     ramp_v;
    int     step_col;
    int     step_row;

    dpcm_gap_pixel_predictor_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pred_error  (o_pred_error),
        .o_mode_tag    (o_mode_tag),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dpcm_gap_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .i_frame_start  (i_frame_start),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_pred_error   (o_pred_error),
        .i_mode_tag     (o_mode_tag),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_tags_seen    (tags_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int clamp_width(int w);
        if (w < int'(MIN_WIDTH_W)) return int'(MIN_WIDTH_W);
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return w;
    endfunction

    // Pixel value for a frame position under the current content style.
    function automatic t_pixel gen_pixel(int row, int col);
        int v;
        case (frame_style)
            STYLE_NOISE: begin
                v = int'($urandom_range(255));
            end
            STYLE_TWO_TONE: begin
                v = ($urandom_range(99) < 80) ? int'(tone_a) : int'(tone_b);
            end
            STYLE_THREE_TONE: begin
                case ($urandom_range(2))
                    0:       v = int'(tone_a);
                    1:       v = int'(tone_b);
                    default: v = int'(tone_c);
                endcase
            end
            STYLE_RAMP: begin
                v = int'(tone_a) + col * ramp_h + row * ramp_v
                    + int'($urandom_range(4)) - 2;
            end
            STYLE_STEP: begin
                v = ((col >= step_col) != (row >= step_row)) ? int'(tone_b) : int'(tone_a);
                if ($urandom_range(9) == 0) v = v + int'($urandom_range(3));
            end
            default: begin
                case ($urandom_range(3))
                    0:       v = 0;
                    1:       v = 255;
                    2:       v = 1;
                    default: v = 254;
                endcase
            end
        endcase
        return t_pixel'(v);
    endfunction

    task automatic pick_frame_content();
        frame_style = t_style'($urandom_range(STYLE_EXTREME));
        tone_a      = t_pixel'($urandom_range(255));
        tone_b      = t_pixel'($urandom_range(255));
        tone_c      = t_pixel'($urandom_range(255));
        ramp_h      = int'($urandom_range(40)) - 20;
        ramp_v      = int'($urandom_range(40)) - 20;
        step_col    = int'($urandom_range(cur_width - 1));
        step_row    = int'($urandom_range(4));
    endtask

    // One pixel transaction; valid stays up until the block takes it.
    task automatic send_pixel(input t_pixel pix, input logic fs);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Full rows plus a partial row; a stray frame start is thrown in now and then.
    task automatic send_frame(input int rows, input int extra, input logic with_start);
        int total;
        logic fs;
        total = rows * cur_width + extra;
        for (int i = 0; i < total; i++) begin
            fs = (with_start && i == 0) || ($urandom_range(299) == 0);
            send_pixel(gen_pixel(i / cur_width, i % cur_width), fs);
        end
        if (with_start) frames_sent++;
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Setup phase, access phase, then psel drops back to idle.
    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_width(input int value);
        write_register(REG_IMAGE_WIDTH, 32'(value));
        cur_width = clamp_width(value & ((1 << WIDTH_BITS) - 1));
    endtask

    function automatic int pick_mode();
        if ($urandom_range(99) < 40) return int'(MODE_CALIC);
        if ($urandom_range(99) < 80) return int'($urandom_range(MODE_WEST, MODE_CALIC));
        return int'($urandom_range((1 << MODE_BITS) - 1));
    endfunction

    function automatic int pick_width();
        int r;
        r = int'($urandom_range(99));
        if (r < 10) return int'($urandom_range(MIN_WIDTH_W - 1));
        if (r < 70) return int'($urandom_range(4, 8));
        return int'($urandom_range(9, 24));
    endfunction

    initial begin
        int phase_base;
        logic shrunk;

        // Synchronous reset, released on a falling edge.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Narrowest rows in CALIC mode: a neighborhood that is uniform except for the
        // upper-right neighbor two rows up must still count as two-valued.
        write_register(REG_PREDICT_MODE, 32'(MODE_CALIC));
        write_width(4);
        for (int f = 0; f < 2; f++) begin
            for (int i = 0; i < 12; i++) begin
                if (i == 3) send_pixel(8'd255, 1'b0);
                else if (i == 10) send_pixel((f == 0) ? 8'd0 : 8'd255, 1'b0);
                else send_pixel(8'd0, i == 0);
            end
            frames_sent++;
        end
        wait_idle();

        // Out-of-range width saturates to the widest row; run the start of a first row.
        write_width((1 << WIDTH_BITS) - 1);
        frame_style = STYLE_RAMP;
        tone_a      = 8'd40;
        ramp_h      = 0;
        ramp_v      = 30;
        send_frame(0, 24, 1'b1);
        wait_idle();
        write_width(8);

        // Random frames under rotating handshake pressure.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            phase_base = items_sent;
            shrunk     = 1'b0;
            while (items_sent - phase_base < PHASE_ITEMS) begin
                wait_idle();
                if ($urandom_range(99) < 60) write_register(REG_PREDICT_MODE, 32'(pick_mode()));
                if ($urandom_range(99) < 50) write_width(pick_width());
                pick_frame_content();
                send_frame(int'($urandom_range(2, 4)), int'($urandom_range(cur_width - 1)),
                           1'b1);
                // Narrow the rows in the middle of a frame and carry on.
                if (!shrunk && cur_width > 4 && $urandom_range(2) == 0) begin
                    wait_idle();
                    write_width(int'($urandom_range(cur_width - 1)));
                    send_frame(int'($urandom_range(2, 3)),
                               int'($urandom_range(cur_width - 1)), 1'b0);
                    shrunk = 1'b1;
                end
            end
        end

        wait_idle();
        $display("Covered %0d pixel results in %0d frames, widths from 4 to %0d, all modes.",
                 result_count, frames_sent, MAX_WIDTH);
        $display("Mode tags observed (one bit per tag): %b, under four pressure patterns.",
                 tags_seen);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
